### hw/rtl/cubic_bspline_pulse_train_oscillator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic B-spline pulse train oscillator
// Same-cycle and next-cycle implication checks with a disable condition.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_PULSE_TRAIN_OSCILLATOR_UNIT_ASSERT_SVH
`define CUBIC_BSPLINE_PULSE_TRAIN_OSCILLATOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CBPO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbpo assertion failed");

// consequent must hold in the cycle after the antecedent
`define CBPO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbpo assertion failed");

`endif

### hw/rtl/cbpo_pkg.sv
// ----------------------------------------------------------------------------
// cbpo_pkg
// Shared types, codes and the control program of the pulse train oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpo_pkg;

   localparam int STEP_W  = 4;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = CSR_IDX_W'(1);

   localparam logic [31:0]        PERIOD_RESET = 32'd6553600;
   localparam logic signed [15:0] GAIN_RESET   = 16'sd16384;

   localparam logic [STEP_W-1:0] ST_IDLE    = STEP_W'(0);
   localparam logic [STEP_W-1:0] ST_MUL_AA  = STEP_W'(1);
   localparam logic [STEP_W-1:0] ST_LD_A2   = STEP_W'(2);
   localparam logic [STEP_W-1:0] ST_MUL_A2A = STEP_W'(3);
   localparam logic [STEP_W-1:0] ST_LD_A3   = STEP_W'(4);
   localparam logic [STEP_W-1:0] ST_LD_KX   = STEP_W'(5);
   localparam logic [STEP_W-1:0] ST_MUL_XM  = STEP_W'(6);
   localparam logic [STEP_W-1:0] ST_LD_KOUT = STEP_W'(7);
   localparam logic [STEP_W-1:0] ST_MUL_KG  = STEP_W'(8);
   localparam logic [STEP_W-1:0] ST_LD_OUT  = STEP_W'(9);

   typedef enum logic [1:0] {
      MUL_AA,
      MUL_A2A,
      MUL_XM,
      MUL_KG
   } mul_sel_type;

   typedef enum logic [2:0] {
      LD_NONE,
      LD_FRONT,
      LD_A2,
      LD_A3,
      LD_KX,
      LD_KOUT,
      LD_OUT
   } load_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_IF_INNER,
      JMP_WAIT_REQ,
      JMP_WAIT_OUT
   } jump_type;

   typedef struct packed {
      mul_sel_type       mul_sel;
      logic              mul_en;
      load_type          load;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mul_en;
      load_type    load;
   } dp_ctrl_type;

   typedef struct packed {
      logic out_free;
      logic outer;
   } dp_status_type;

   function automatic ctrl_word_type prog_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{mul_sel: MUL_AA, mul_en: 1'b0, load: LD_NONE, jump: JMP_NEXT, target: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            w.load = LD_FRONT;
            w.jump = JMP_WAIT_REQ;
         end
         ST_MUL_AA: begin
            w.mul_sel = MUL_AA;
            w.mul_en  = 1'b1;
         end
         ST_LD_A2:   w.load = LD_A2;
         ST_MUL_A2A: begin
            w.mul_sel = MUL_A2A;
            w.mul_en  = 1'b1;
         end
         ST_LD_A3:   w.load = LD_A3;
         ST_LD_KX: begin
            w.load   = LD_KX;
            w.jump   = JMP_IF_INNER;
            w.target = ST_MUL_KG;
         end
         ST_MUL_XM: begin
            w.mul_sel = MUL_XM;
            w.mul_en  = 1'b1;
         end
         ST_LD_KOUT: w.load = LD_KOUT;
         ST_MUL_KG: begin
            w.mul_sel = MUL_KG;
            w.mul_en  = 1'b1;
         end
         ST_LD_OUT: begin
            w.load   = LD_OUT;
            w.jump   = JMP_WAIT_OUT;
            w.target = ST_IDLE;
         end
         default: begin
            w.jump   = JMP_ALWAYS;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/cbpo_sequencer.sv
// ----------------------------------------------------------------------------
// cbpo_sequencer
// Step counter and program table; issues one control word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpo_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire cbpo_pkg::dp_status_type status,
   output cbpo_pkg::dp_ctrl_type       ctrl,
   output logic                       req_ready
);
   import cbpo_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_word_type     word;
   logic              fire;

   always_comb begin
      word = prog_word(step_ff);
   end

   always_comb begin
      unique case (word.jump)
         JMP_WAIT_REQ: fire = req_valid;
         JMP_WAIT_OUT: fire = status.out_free;
         default:      fire = 1'b1;
      endcase
   end

   always_comb begin
      unique case (word.jump)
         JMP_NEXT:     step_in = step_ff + STEP_W'(1);
         JMP_ALWAYS:   step_in = word.target;
         JMP_IF_INNER: step_in = status.outer ? step_ff + STEP_W'(1) : word.target;
         JMP_WAIT_REQ: step_in = fire ? step_ff + STEP_W'(1) : step_ff;
         JMP_WAIT_OUT: step_in = fire ? word.target : step_ff;
         default:      step_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.mul_sel = word.mul_sel;
      ctrl.mul_en  = word.mul_en & fire;
      ctrl.load    = fire ? word.load : LD_NONE;
      req_ready    = (word.jump == JMP_WAIT_REQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cbpo_mul.sv
// ----------------------------------------------------------------------------
// cbpo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpo_mul #(
   parameter int W = 19
) (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic signed [W-1:0]   op_a,
   input  wire logic signed [W-1:0]   op_b,
   output logic signed [2*W-1:0]      product
);

   logic signed [2*W-1:0] product_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= op_a * op_b;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

### hw/rtl/cbpo_datapath.sv
// ----------------------------------------------------------------------------
// cbpo_datapath
// Position, kernel registers, gain scaling, output register and settings.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpo_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cbpo_pkg::dp_ctrl_type                ctrl,
   input  wire logic                                advance,
   input  wire logic                                csr_valid,
   input  wire logic [cbpo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [31:0]                         csr_data,
   input  wire logic                                rsp_ready,
   output cbpo_pkg::dp_status_type                   status,
   output logic                                     rsp_valid,
   output logic [15:0]                              rsp_sample
);
   import cbpo_pkg::*;

   localparam int AW = FRAC_BITS + 1;
   localparam int S  = AW + 1;
   localparam int OW = (FRAC_BITS + 3 > 16) ? FRAC_BITS + 3 : 16;
   localparam int PW = 2 * OW;

   localparam logic [31:0]    ONE   = 32'(1) << FRAC_BITS;
   localparam logic [31:0]    ONE2  = ONE << 1;
   localparam logic [31:0]    ONE3  = ONE2 + ONE;
   localparam logic [31:0]    ONE4  = ONE << 2;
   localparam logic [AW-1:0]  TWO_THIRDS = AW'(((2 << FRAC_BITS) + 1) / 3);
   localparam logic [S-1:0]   RECIP = S'((2 ** S) / 3);
   localparam logic [PW-1:0]  RND_KERNEL = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] RND_OUT = PW'(1) << (FRAC_BITS - 2);
   localparam logic signed [PW-1:0] SAT_HI  = PW'(32767);
   localparam logic signed [PW-1:0] SAT_LO  = PW'(-32768);

   logic [31:0]        t_ff, t_in;
   logic [31:0]        period_ff, period_in;
   logic signed [15:0] gain_ff, gain_in;
   logic               adv_ff, adv_in;
   logic               outer_ff, outer_in;
   logic               zero_ff, zero_in;
   logic [AW-1:0]      a_ff, a_in;
   logic [AW-1:0]      a2_ff, a2_in;
   logic [AW-1:0]      a3_ff, a3_in;
   logic [AW-1:0]      x_ff, x_in;
   logic [AW-1:0]      k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        sample_ff, sample_in;

   logic signed [OW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod;
   logic [PW-1:0]        prod_rnd;
   logic [AW-1:0]        prod_q;
   logic [AW:0]          half_a3, x_wide, k_inner;
   logic [AW-1:0]        q, rem;
   logic signed [PW-1:0] scaled, shifted;
   logic [32:0]          t_inc, t_wrap;
   logic                 out_free;

   cbpo_mul #(.W(OW)) u_mul (
      .clock   (clock),
      .enable  (ctrl.mul_en),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (prod)
   );

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_AA: begin
            op_a = $signed({{(OW-AW){1'b0}}, a_ff});
            op_b = $signed({{(OW-AW){1'b0}}, a_ff});
         end
         MUL_A2A: begin
            op_a = $signed({{(OW-AW){1'b0}}, a2_ff});
            op_b = $signed({{(OW-AW){1'b0}}, a_ff});
         end
         MUL_XM: begin
            op_a = $signed({{(OW-AW){1'b0}}, x_ff});
            op_b = $signed({{(OW-S){1'b0}}, RECIP});
         end
         MUL_KG: begin
            op_a = zero_ff ? '0 : $signed({{(OW-AW){1'b0}}, k_ff});
            op_b = OW'(gain_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      prod_rnd = $unsigned(prod) + RND_KERNEL;
      prod_q   = AW'(prod_rnd >> FRAC_BITS);
      half_a3  = ({1'b0, a3_ff} + (AW+1)'(1)) >> 1;
      x_wide   = ({1'b0, a3_ff} + (AW+1)'(3)) >> 1;
      k_inner  = {1'b0, TWO_THIRDS} + half_a3 - {1'b0, a2_ff};
      q        = AW'($unsigned(prod) >> S);
      rem      = x_ff - (q + AW'({q, 1'b0}));
      scaled   = prod + RND_OUT;
      shifted  = scaled >>> (FRAC_BITS - 1);
      t_inc    = {1'b0, t_ff} + {1'b0, ONE};
      t_wrap   = (t_inc >= {1'b0, period_ff}) ? t_inc - {1'b0, period_ff} : t_inc;
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      t_in         = t_ff;
      period_in    = period_ff;
      gain_in      = gain_ff;
      adv_in       = adv_ff;
      outer_in     = outer_ff;
      zero_in      = zero_ff;
      a_in         = a_ff;
      a2_in        = a2_ff;
      a3_in        = a3_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         if (csr_index == CSR_PERIOD) begin
            period_in = csr_data;
         end else if (csr_index == CSR_GAIN) begin
            gain_in = $signed(csr_data[15:0]);
         end
      end

      unique case (ctrl.load)
         LD_FRONT: begin
            adv_in  = advance;
            zero_in = (t_ff >= ONE4);
            priority if (t_ff >= ONE3) begin
               a_in     = AW'(ONE4 - t_ff);
               outer_in = 1'b1;
            end else if (t_ff >= ONE2) begin
               a_in     = AW'(t_ff - ONE2);
               outer_in = 1'b0;
            end else if (t_ff >= ONE) begin
               a_in     = AW'(ONE2 - t_ff);
               outer_in = 1'b0;
            end else begin
               a_in     = AW'(t_ff);
               outer_in = 1'b1;
            end
         end
         LD_A2: a2_in = prod_q;
         LD_A3: a3_in = prod_q;
         LD_KX: begin
            k_in = AW'(k_inner);
            x_in = AW'(x_wide);
         end
         LD_KOUT: k_in = q + AW'(rem >= AW'(3));
         LD_OUT: begin
            priority if (shifted > SAT_HI) begin
               sample_in = 16'h7fff;
            end else if (shifted < SAT_LO) begin
               sample_in = 16'h8000;
            end else begin
               sample_in = shifted[15:0];
            end
            rsp_valid_in = 1'b1;
            if (adv_ff) begin
               t_in = t_wrap[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff         <= '0;
         period_ff    <= PERIOD_RESET;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         t_ff         <= t_in;
         period_ff    <= period_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adv_ff    <= adv_in;
      outer_ff  <= outer_in;
      zero_ff   <= zero_in;
      a_ff      <= a_in;
      a2_ff     <= a2_in;
      a3_ff     <= a3_in;
      x_ff      <= x_in;
      k_ff      <= k_in;
      sample_ff <= sample_in;
   end

   assign status.out_free = out_free;
   assign status.outer    = outer_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = sample_ff;

endmodule

`default_nettype wire

### hw/rtl/cubic_bspline_pulse_train_oscillator_unit.sv
// Steps: an item with t in [1,3) is handled as the inner pieces and skips the
// 1/3 multiply and its load; t < 1 and t >= 3, including t past the support, take it.
// Items are taken one at a time: a new item is accepted only once the program of the
// sequencer around the single shared multiplier (a*a, a2*a, 1/3, gain) has finished.
// Reset: synchronous; position clears to zero, period and gain take defaults.
// ----------------------------------------------------------------------------
// cubic_bspline_pulse_train_oscillator_unit
// Cubic B-spline pulse train oscillator, one sample per input item.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bspline_pulse_train_oscillator_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [0] advance
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [15:0]                            rsp_tdata,   // [15:0] sample_out
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cbpo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [31:0]                       csr_data
);
   import cbpo_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   cbpo_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .status    (status),
      .ctrl      (ctrl),
      .req_ready (req_tready)
   );

   cbpo_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .advance    (req_tdata[0]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_ready  (rsp_tready),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_sample (rsp_tdata)
   );

   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

### hw/rtl/cbpo_checker.sv
// ----------------------------------------------------------------------------
// cbpo_checker
// Port-level checks of the pulse train oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_bspline_pulse_train_oscillator_unit_assert.svh"

module cbpo_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [15:0]                       rsp_tdata,
   input wire logic                              csr_valid,
   input wire logic                              csr_ready,
   input wire logic [cbpo_pkg::CSR_IDX_W-1:0]    csr_index
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   `CBPO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CBPO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)
   `CBPO_ASSERT_NEXT(a_no_early_result, clock, reset, req_fire && !rsp_tvalid, !rsp_tvalid)
   `CBPO_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid)
   `CBPO_ASSERT_NOW(a_csr_idx_known, clock, reset, csr_valid && csr_ready, !$isunknown(csr_index))

endmodule

bind cubic_bspline_pulse_train_oscillator_unit cbpo_checker u_checker (.*);

`default_nettype wire
